// ===== rtl/selective_repeat_receive_window_core_defines.svh =====
// Assertion macros shared by the receive window RTL.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_DEFINES_SVH

// Property checked on aclk, held off while aresetn is low.
`define SRRW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be true on a clock edge outside reset.
`define SRRW_NEVER(lbl, expr, msg) \
    `SRRW_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/srrw_pkg.sv =====
// Shared types and constants of the selective-repeat receive window.
`default_nettype none

package srrw_pkg;

    // Field widths
    localparam int CFG_W      = 5;
    localparam int TYPE_W     = 2;
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 11;
    localparam int OUT_SLOT_W = 4;
    localparam int TDATA_W    = 48;

    // Window size after reset
    localparam logic [CFG_W-1:0] WIN_RESET = 5'd16;

    // Packet types
    localparam logic [TYPE_W-1:0] REQ_DATA = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_END  = 2'd1;

    // Result kinds
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Modulo unit: dividend bits consumed per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = SEQ_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Classified packet passed from front to back
    typedef struct packed {
        logic             is_end;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } pkt_t;

    // One result word
    typedef struct packed {
        logic                  kind;
        logic [SEQ_W-1:0]      seq;
        logic [OUT_SLOT_W-1:0] slot;
        logic [LEN_W-1:0]      len;
        logic                  done;
        logic                  last;
    } result_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CLASS,
        B_OOW,
        B_DRAIN_RD,
        B_DRAIN_OUT,
        B_ACK,
        B_END
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/selective_repeat_receive_window_core.sv =====
// Top level of the selective-repeat receive window.
//
//  channel  dir  handshake          tdata (low bit up)                     tuser      tlast
//  s_       in   s_tvalid/s_tready  seq_num, checksum_ok, payload_len      req_type   -
//  m_       out  m_tvalid/m_tready  out_seq, out_slot, out_len, out_done   out_kind   out_last
//  cfg_     in   cfg_wr_en          slot count (5 bits)                    -          -
//
// The front holds one packet: it drops a bad word on accept, pushes an END word after accept,
// and runs a data word through the 8-bit-a-cycle slot modulo unit before pushing it. The back
// fetches and classifies, emits acks, and reads each delivered slot's length from the registered
// length RAM first; a drain that stops on an empty slot or a full window also passes that read
// state. A 2-entry queue separates the two; a stalled m_tready holds the back while the front
// keeps accepting until the queue fills. Reset is synchronous and needs no clearing pass.
`default_nettype none

module selective_repeat_receive_window_core import srrw_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,  // seq_num[31:0], checksum_ok[32], payload_len[43:33]
    input  wire logic [TYPE_W-1:0]  s_tuser,  // req_type[1:0]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,  // out_seq[31:0], out_slot[35:32], out_len[46:36], out_done[47]
    output logic      [0:0]         m_tuser,  // out_kind[0]
    output logic                    m_tlast
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WMAX   = (WINDOW > 31) ? 31 : WINDOW;
    localparam int QDEPTH = 2;
    localparam int QW     = $bits(pkt_t) + SLOT_W;

    logic [CFG_W-1:0]  win_cfg_reg;
    logic [CFG_W-1:0]  win;
    logic              push;
    pkt_t              push_pkt;
    logic [SLOT_W-1:0] push_slot;
    logic              fifo_full;
    logic              pop;
    logic              empty;
    logic [QW-1:0]     pop_data;
    pkt_t              pop_pkt;
    logic [SLOT_W-1:0] pop_slot;

    // Window size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg <= WIN_RESET;
        end else if (cfg_wr_en) begin
            win_cfg_reg <= cfg_wr_data;
        end
    end

    // Clamp to the slots available
    always_comb begin
        if (win_cfg_reg == '0) begin
            win = CFG_W'(1);
        end else if (32'(win_cfg_reg) > WMAX) begin
            win = CFG_W'(WMAX);
        end else begin
            win = win_cfg_reg;
        end
    end

    srrw_front #(
        .SLOT_W (SLOT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win       (win),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_pkt  (push_pkt),
        .push_slot (push_slot),
        .fifo_full (fifo_full)
    );

    srrw_fifo #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_slot, push_pkt}),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    assign pop_pkt  = pop_data[$bits(pkt_t)-1:0];
    assign pop_slot = pop_data[QW-1:$bits(pkt_t)];

    srrw_back #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .win      (win),
        .empty    (empty),
        .pop      (pop),
        .pop_pkt  (pop_pkt),
        .pop_slot (pop_slot),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/srrw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/srrw_fifo.sv =====
// Short queue of classified packets between front and back.
`default_nettype none
`include "selective_repeat_receive_window_core_defines.svh"

module srrw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SRRW_NEVER(a_fifo_no_overflow, push && full, "queue pushed while full")
    `SRRW_NEVER(a_fifo_no_underflow, pop && empty, "queue popped while empty")

endmodule

`default_nettype wire

// ===== rtl/srrw_front.sv =====
// Front end: accepts packet words, drops bad ones, computes the window slot.
`default_nettype none

module srrw_front import srrw_pkg::*; #(
    parameter int SLOT_W = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CFG_W-1:0]   win,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,  // seq_num, checksum_ok, payload_len
    input  wire logic [TYPE_W-1:0]  s_tuser,  // req_type
    output logic                    push,
    output pkt_t                    push_pkt,
    output logic      [SLOT_W-1:0]  push_slot,
    input  wire logic               fifo_full
);

    front_state_t      state_reg, state_next;
    pkt_t              pkt_reg;
    logic [SEQ_W-1:0]  dividend_reg;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg;
    logic              accept;
    logic              keep;
    logic              is_data;

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_data  = (s_tuser == REQ_DATA);
    assign keep     = s_tdata[32] && (is_data || (s_tuser == REQ_END));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept && keep) begin
                    state_next = is_data ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!fifo_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        push      = (state_reg == F_PUSH) && !fifo_full;
        push_pkt  = pkt_reg;
        push_slot = SLOT_W'(rem_reg);
    end

    // Restoring remainder, several dividend bits a cycle
    always_comb begin
        logic [CFG_W:0]   t;
        logic [CFG_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            t = {r, dividend_reg[SEQ_W-1-k]};
            if (t >= {1'b0, win}) begin
                r = CFG_W'(t - {1'b0, win});
            end else begin
                r = t[CFG_W-1:0];
            end
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the packet, then step the remainder
    always_ff @(posedge aclk) begin
        if (accept) begin
            pkt_reg.is_end <= !is_data;
            pkt_reg.seq    <= s_tdata[31:0];
            pkt_reg.len    <= s_tdata[43:33];
            dividend_reg   <= s_tdata[31:0];
            rem_reg        <= '0;
            step_reg       <= '0;
        end else if (state_reg == F_DIV) begin
            dividend_reg <= dividend_reg << DIV_BITS;
            rem_reg      <= rem_next;
            step_reg     <= STEP_W'(step_reg + 1'b1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srrw_back.sv =====
// Back end: window state, slot buffering, in-order drain and acks.
`default_nettype none
`include "selective_repeat_receive_window_core_defines.svh"

module srrw_back import srrw_pkg::*; #(
    parameter int WINDOW = 16,
    parameter int SLOT_W = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CFG_W-1:0]   win,
    input  wire logic               empty,
    output logic                    pop,
    input  wire pkt_t               pop_pkt,
    input  wire logic [SLOT_W-1:0]  pop_slot,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata,  // out_seq, out_slot, out_len, out_done
    output logic      [0:0]         m_tuser,  // out_kind
    output logic                    m_tlast
);

    back_state_t       state_reg, state_next;
    pkt_t              cur_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [SEQ_W-1:0]  ne_reg;
    logic              end_seen_reg;
    logic [SEQ_W-1:0]  end_num_reg;
    logic              finished_reg;
    logic [WINDOW-1:0] valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CFG_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              out_free;
    logic [SEQ_W-1:0]  off;
    logic              in_win;
    logic              end_hit;
    logic              drain_stop;
    logic [SEQ_W-1:0]  ne_inc;
    logic              end_after_deliver;
    logic [SLOT_W:0]   slot_p1;
    logic [SLOT_W-1:0] slot_inc;
    logic              ram_we;
    logic              ram_re;
    logic [LEN_W-1:0]  ram_rdata;
    logic              emit;
    result_t           result;

    // Length store, one entry per slot
    srrw_ram #(
        .WIDTH (LEN_W),
        .DEPTH (WINDOW)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_slot_reg),
        .wdata (cur_reg.len),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Window tests
    assign out_free          = !out_valid_reg || m_tready;
    assign off               = cur_reg.seq - ne_reg;
    assign in_win            = (off < SEQ_W'(win));
    assign end_hit           = end_seen_reg && (ne_reg >= end_num_reg);
    assign drain_stop        = (cnt_reg == win) || !valid_reg[slot_reg];
    assign ne_inc            = ne_reg + 1'b1;
    assign end_after_deliver = end_seen_reg && (ne_inc == end_num_reg);
    assign slot_p1           = {1'b0, slot_reg} + 1'b1;
    assign slot_inc          = (slot_p1 == (SLOT_W + 1)'(win)) ? '0 : slot_p1[SLOT_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    state_next = B_CLASS;
                end
            end
            B_CLASS: begin
                if (finished_reg) begin
                    state_next = B_IDLE;
                end else if (cur_reg.is_end) begin
                    state_next = (ne_reg >= cur_reg.seq) ? B_END : B_IDLE;
                end else if (!in_win) begin
                    state_next = B_OOW;
                end else if (off == '0) begin
                    state_next = B_DRAIN_RD;
                end else begin
                    state_next = B_ACK;
                end
            end
            B_OOW: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            B_DRAIN_RD: begin
                state_next = drain_stop ? B_ACK : B_DRAIN_OUT;
            end
            B_DRAIN_OUT: begin
                if (out_free) begin
                    state_next = end_after_deliver ? B_ACK : B_DRAIN_RD;
                end
            end
            B_ACK: begin
                if (out_free) begin
                    state_next = end_hit ? B_END : B_IDLE;
                end
            end
            B_END: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        pop         = (state_reg == B_IDLE) && !empty;
        ram_we      = (state_reg == B_CLASS) && !finished_reg && !cur_reg.is_end && in_win;
        ram_re      = (state_reg == B_DRAIN_RD) && !drain_stop;
        emit        = 1'b0;
        result.kind = KIND_ACK;
        result.seq  = ne_reg;
        result.slot = '0;
        result.len  = '0;
        result.done = 1'b0;
        result.last = 1'b0;
        case (state_reg)
            B_OOW: begin
                emit        = out_free;
                result.last = 1'b1;
            end
            B_DRAIN_OUT: begin
                emit        = out_free;
                result.kind = KIND_DELIVER;
                result.slot = OUT_SLOT_W'(slot_reg);
                result.len  = ram_rdata;
            end
            B_ACK: begin
                emit        = out_free;
                result.last = !end_hit;
            end
            B_END: begin
                emit        = out_free;
                result.seq  = end_num_reg;
                result.done = 1'b1;
                result.last = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    // Window control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            ne_reg        <= '0;
            end_seen_reg  <= 1'b0;
            end_num_reg   <= '0;
            finished_reg  <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Record the end number
            if ((state_reg == B_CLASS) && !finished_reg && cur_reg.is_end) begin
                end_seen_reg <= 1'b1;
                end_num_reg  <= cur_reg.seq;
            end
            // Mark the buffered slot
            if (ram_we) begin
                valid_reg[cur_slot_reg] <= 1'b1;
            end
            // Release a delivered slot and advance
            if ((state_reg == B_DRAIN_OUT) && out_free) begin
                valid_reg[slot_reg] <= 1'b0;
                ne_reg              <= ne_inc;
            end
            if ((state_reg == B_END) && out_free) begin
                finished_reg <= 1'b1;
            end
            // Output register
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working packet, drain cursor and result word
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg      <= pop_pkt;
            cur_slot_reg <= pop_slot;
        end
        if (ram_we) begin
            slot_reg <= cur_slot_reg;
            cnt_reg  <= '0;
        end else if ((state_reg == B_DRAIN_OUT) && out_free) begin
            slot_reg <= slot_inc;
            cnt_reg  <= CFG_W'(cnt_reg + 1'b1);
        end
        if (emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.done, out_reg.len, out_reg.slot, out_reg.seq};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    `SRRW_ASSERT(a_finished_sticky, finished_reg |=> finished_reg, "finished flag dropped")
    `SRRW_ASSERT(a_deliver_valid, (state_reg == B_DRAIN_OUT) |-> valid_reg[slot_reg], "delivering an empty slot")
    `SRRW_ASSERT(a_end_ahead, (state_reg == B_IDLE && end_seen_reg && !finished_reg) |-> (ne_reg < end_num_reg), "end reached without finishing")

endmodule

`default_nettype wire

// ===== tb/srrw_window_checker.sv =====
// Checker for the receive window core: predicts the result words and compares them.
`default_nettype none

module srrw_window_checker import srrw_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic [TYPE_W-1:0]  s_tuser,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    input  wire logic [0:0]         m_tuser,
    input  wire logic               m_tlast,
    output int                      fail_count,
    output int                      pending,
    output logic      [SEQ_W-1:0]   rx_next_seq
);

    // Mirror of the receive window state
    logic [CFG_W-1:0] win_cfg;
    logic [SEQ_W-1:0] rx_next;
    logic [SEQ_W-1:0] seen_top;
    logic             end_valid;
    logic [SEQ_W-1:0] end_mark;
    logic             xfer_done;
    logic             slot_full  [WINDOW];
    logic [LEN_W-1:0] slot_bytes [WINDOW];

    result_t expected_words[$];
    int      errs = 0;

    function automatic int unsigned slots_in_use();
        if (win_cfg == 0) return 1;
        if (win_cfg > WINDOW) return WINDOW;
        return 32'(win_cfg);
    endfunction

    function automatic result_t make_word(logic kind, logic [SEQ_W-1:0] seq,
                                          logic [OUT_SLOT_W-1:0] slot,
                                          logic [LEN_W-1:0] len, logic done);
        result_t r;
        r.kind = kind;
        r.seq  = seq;
        r.slot = slot;
        r.len  = len;
        r.done = done;
        r.last = 1'b0;
        return r;
    endfunction

    // Render one result word for a report line
    function automatic string fmt_word(input result_t r);
        return $sformatf("kind=%0d seq=%0d slot=%0d len=%0d done=%0d last=%0d",
                         r.kind, r.seq, r.slot, r.len, r.done, r.last);
    endfunction

    // Work out the words one accepted packet header causes
    task automatic predict_packet(input logic [TYPE_W-1:0] typ, input logic [SEQ_W-1:0] seq,
                                  input logic ok, input logic [LEN_W-1:0] len);
        int unsigned w;
        int unsigned s;
        int          first;
        logic [SEQ_W-1:0] off;
        result_t     r;
        w     = slots_in_use();
        first = expected_words.size();
        // drop damaged, unknown and post-finish packets
        if (xfer_done || !ok || (typ != REQ_DATA && typ != REQ_END)) return;
        if (typ == REQ_END) begin
            end_valid = 1'b1;
            end_mark  = seq;
            if (rx_next >= end_mark) begin
                expected_words.push_back(make_word(KIND_ACK, end_mark, '0, '0, 1'b1));
                xfer_done = 1'b1;
            end
        end else begin
            off = seq - rx_next;
            if (off >= w) begin
                // outside the window: cumulative ack only
                expected_words.push_back(make_word(KIND_ACK, rx_next, '0, '0, 1'b0));
            end else begin
                s = seq % w;
                slot_full[s]  = 1'b1;
                slot_bytes[s] = len;
                if (off != 0) begin
                    if (seq >= seen_top) seen_top = seq + 1;
                end else begin
                    // drain consecutive buffered slots in order
                    for (int i = 0; i < w; i++) begin
                        s = rx_next % w;
                        if (!slot_full[s]) break;
                        expected_words.push_back(make_word(KIND_DELIVER, rx_next,
                                                           OUT_SLOT_W'(s), slot_bytes[s], 1'b0));
                        slot_full[s] = 1'b0;
                        rx_next++;
                        if (end_valid && rx_next == end_mark) break;
                        if (rx_next >= seen_top) seen_top = rx_next;
                    end
                end
                expected_words.push_back(make_word(KIND_ACK, rx_next, '0, '0, 1'b0));
                if (end_valid && rx_next >= end_mark) begin
                    expected_words.push_back(make_word(KIND_ACK, end_mark, '0, '0, 1'b1));
                    xfer_done = 1'b1;
                end
            end
        end
        // flag the final word of this packet
        if (expected_words.size() > first) begin
            r = expected_words.pop_back();
            r.last = 1'b1;
            expected_words.push_back(r);
        end
    endtask

    // Watch both channels and the register port
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            win_cfg   = WIN_RESET;
            rx_next   = '0;
            seen_top  = '0;
            end_valid = 1'b0;
            end_mark  = '0;
            xfer_done = 1'b0;
            foreach (slot_full[i]) begin
                slot_full[i]  = 1'b0;
                slot_bytes[i] = '0;
            end
            expected_words.delete();
        end else begin
            if (cfg_wr_en) win_cfg = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser[0];
                got.seq  = m_tdata[31:0];
                got.slot = m_tdata[35:32];
                got.len  = m_tdata[46:36];
                got.done = m_tdata[47];
                got.last = m_tlast;
                if (expected_words.size() == 0) begin
                    errs++;
                    $display("%0t: expected no word, got %s", $time, fmt_word(got));
                end else begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind || got.seq !== want.seq ||
                        got.slot !== want.slot || got.len !== want.len ||
                        got.done !== want.done || got.last !== want.last) begin
                        errs++;
                        $display("%0t: mismatch expected %s, got %s",
                                 $time, fmt_word(want), fmt_word(got));
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_packet(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[43:33]);
        end
        fail_count  <= errs;
        pending     <= expected_words.size();
        rx_next_seq <= rx_next;
    end

endmodule

`default_nettype wire

// ===== tb/selective_repeat_receive_window_core_tb.sv =====
// Testbench top for the receive window core: stimulus, stalls, watchdog and verdict.
`default_nettype none

module selective_repeat_receive_window_core_tb import srrw_pkg::*;;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 54;

    // Packet types the core drops
    localparam logic [TYPE_W-1:0] REQ_OTHER    = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata     = '0;
    logic [TYPE_W-1:0]  s_tuser     = '0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               m_tlast;

    int               fail_count;
    int               pending;
    logic [SEQ_W-1:0] rx_next_seq;

    bit               calm        = 1'b0;
    int               stall_left  = 0;
    int               idle_cycles = 0;
    int               live_items  = 0;
    int unsigned      win_eff     = 16;
    logic [SEQ_W-1:0] base        = '0;

    selective_repeat_receive_window_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    srrw_window_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .rx_next_seq (rx_next_seq)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // Random payload length
    function automatic logic [LEN_W-1:0] rand_len();
        return LEN_W'($urandom_range(0, 2047));
    endfunction

    // Stall the result channel at random
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // End the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no word moved for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one packet header and hold it until accepted
    task automatic send_word(input logic [TYPE_W-1:0] typ, input logic [SEQ_W-1:0] seq,
                             input logic ok, input logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, len, ok, seq};
        s_tuser  <= typ;
        do @(posedge aclk); while (!s_tready);
        if (ok && (typ == REQ_DATA || typ == REQ_END)) live_items++;
    endtask

    // Hold the sender until every expected word is out, then let the core go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        win_eff = (v == 0) ? 1 : ((v > 16) ? 16 : v);
    endtask

    // Drop in a damaged, foreign, duplicate or stray packet
    task automatic send_noise(input int k);
        case ($urandom_range(0, 4))
            0: send_word($urandom_range(0, 1) ? REQ_OTHER : REQ_RESERVED, $urandom(),
                         1'($urandom_range(0, 1)), rand_len());
            1: send_word(TYPE_W'($urandom_range(0, 3)), base + $urandom_range(0, k - 1), 1'b0,
                         rand_len());
            2: send_word(REQ_DATA, $urandom(), 1'b1, rand_len());
            3: send_word(REQ_DATA, base + $urandom_range(0, k - 1), 1'b1, rand_len());
            default: send_word(REQ_END, $urandom_range(32'hFFFF_FFFF, base + 32'd5000), 1'b1,
                               rand_len());
        endcase
    endtask

    // Up to one window's worth of consecutive packets, possibly reordered, with noise mixed in
    task automatic run_batch();
        logic [SEQ_W-1:0] order[$];
        logic [SEQ_W-1:0] t;
        int k;
        int j;
        k = ($urandom_range(0, 3) == 0) ? win_eff : $urandom_range(1, win_eff);
        for (int i = 0; i < k; i++) order.push_back(base + i);
        if ($urandom_range(0, 2) != 0) begin
            for (int i = k - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        foreach (order[i]) begin
            if ($urandom_range(0, 9) == 0) send_noise(k);
            send_word(REQ_DATA, order[i], 1'b1, rand_len());
        end
        base += k;
    endtask

    initial begin : stim
        logic [CFG_W-1:0] win_plan[$];
        int phase_end;
        int k;
        win_plan = '{5'd1, 5'd0, 5'd31, 5'd7, 5'd3, 5'd20, 5'd16};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: drops, window edges, duplicates, far END, in-order drains
        send_word(REQ_OTHER, 32'hFFFF_FFFF, 1'b1, 11'h7FF);
        send_word(REQ_RESERVED, 32'h0, 1'b1, 11'h0);
        send_word(REQ_DATA, 32'h0, 1'b0, 11'h7FF);
        send_word(REQ_DATA, 32'hFFFF_FFFF, 1'b1, 11'h7FF);
        send_word(REQ_DATA, 32'd16, 1'b1, 11'h0);
        send_word(REQ_DATA, 32'd15, 1'b1, 11'h0);
        send_word(REQ_DATA, 32'd3, 1'b1, 11'h7FF);
        send_word(REQ_DATA, 32'd3, 1'b1, 11'd5);
        send_word(REQ_END, 32'hFFFF_FFFF, 1'b1, 11'h0);
        send_word(REQ_DATA, 32'd0, 1'b1, 11'h2AA);
        send_word(REQ_DATA, 32'd2, 1'b1, 11'h555);
        send_word(REQ_DATA, 32'd1, 1'b1, 11'h400);
        for (int i = 14; i >= 4; i--) send_word(REQ_DATA, i, 1'b1, rand_len());
        send_word(REQ_DATA, 32'd0, 1'b1, 11'd7);
        // leave a slot filled, then shrink the window so it reads as stale
        send_word(REQ_DATA, 32'd21, 1'b1, 11'd9);
        settle();
        write_window(5'd6);
        send_word(REQ_DATA, 32'd16, 1'b1, 11'd1);

        // Random phases, one window setting each
        foreach (win_plan[p]) begin
            settle();
            write_window(win_plan[p]);
            base = rx_next_seq;
            calm = ($urandom_range(0, 2) == 0);
            phase_end = live_items + PHASE_ITEMS;
            while (live_items < phase_end) run_batch();
        end

        // Finish the transfer: END ahead, one packet at the END number, then the run below it
        settle();
        calm = 1'b0;
        write_window(5'd16);
        base = rx_next_seq;
        k = $urandom_range(2, 13);
        send_word(REQ_END, base + k, 1'b1, rand_len());
        send_word(REQ_DATA, base + k, 1'b1, rand_len());
        for (int i = k - 1; i >= 0; i--) send_word(REQ_DATA, base + i, 1'b1, rand_len());
        // everything after the finish is ignored
        send_word(REQ_DATA, base + k + 1, 1'b1, 11'h3);
        send_word(REQ_END, 32'h0, 1'b1, 11'h0);
        send_word(REQ_DATA, $urandom(), 1'b1, 11'h7FF);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== selective_repeat_receive_window_core.f =====
+incdir+rtl
rtl/srrw_pkg.sv
rtl/srrw_ram.sv
rtl/srrw_fifo.sv
rtl/srrw_front.sv
rtl/srrw_back.sv
rtl/selective_repeat_receive_window_core.sv
tb/srrw_window_checker.sv
tb/selective_repeat_receive_window_core_tb.sv
